>>> src/kmt_pkg.sv
// Shared types and command codes for the killer move table.
// No dependencies; used by killer_move_table.
`default_nettype none
package kmt_pkg;

  localparam logic [1:0] CMD_UPDATE  = 2'd0;
  localparam logic [1:0] CMD_APPEND  = 2'd1;
  localparam logic [1:0] CMD_PROMOTE = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  typedef struct packed {
    logic [4:0]         x;
    logic [4:0]         y;
    logic signed [31:0] score;
  } move_t;

  typedef struct packed {
    logic  valid;
    move_t mv;
  } slot_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [4:0]         ply;
    logic [4:0]         move_x;
    logic [4:0]         move_y;
    logic signed [31:0] move_score;
    logic [7:0]         list_index;
    logic               list_start;
  } req_t;

  typedef struct packed {
    logic [4:0]         out_x;
    logic [4:0]         out_y;
    logic signed [31:0] out_score;
    logic               out_valid;
  } rsp_t;

endpackage
`default_nettype wire

>>> src/kmt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module kmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/killer_move_table.sv
// Killer move table: per-ply killer slots in one RAM, move list in another.
// Append writes the list RAM directly; update rewrites the killer row. Read
// registers its response from the list RAM, or gives an empty response when
// the index is past the count. Promote scans the list through the single read
// port of the list RAM, moving killer matches to the front. One request is in work
// at a time, and a response waiting at the output holds off the next request.
// Reset (rst, synchronous) clears all killer rows through per-row valid bits
// and empties the list; list contents stay undefined until written.
`default_nettype none
module killer_move_table #(
  parameter int MAX_PLY       = 16,
  parameter int SLOTS_PER_PLY = 2,
  parameter int LIST_DEPTH    = 256
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire kmt_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output kmt_pkg::rsp_t      rsp
);
  import kmt_pkg::*;

  localparam int S   = SLOTS_PER_PLY;
  localparam int PW  = (MAX_PLY > 1) ? $clog2(MAX_PLY) : 1;
  localparam int PD  = (MAX_PLY > 1) ? MAX_PLY : 2;
  localparam int AW  = $clog2(LIST_DEPTH);
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int MW  = $clog2(S + 1);
  localparam int IW  = (CW > 8) ? CW : 8;
  localparam int RWD = S * $bits(slot_t);

  typedef enum logic [2:0] {
    IDLE, UPD, RD, P_ROW, P_SCAN, P_SHIFT, P_PUT
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [PD-1:0]     row_vld;
  logic [PW-1:0]     pply;
  move_t             pmv;
  slot_t [S-1:0]     kr;
  logic [AW-1:0]     scan_i;
  logic [AW-1:0]     last;
  logic [AW-1:0]     sh_j;
  logic [MW-1:0]     m;
  logic [MW-1:0]     k;
  logic [AW-1:0]     midx [S];
  move_t             mmv  [S];

  // Killer RAM: one row of all slots per ply.
  logic              k_we;
  logic [PW-1:0]     k_raddr;
  logic [RWD-1:0]    k_wdata, k_rdata;
  // List RAM.
  logic              l_we;
  logic [AW-1:0]     l_waddr, l_raddr;
  move_t             l_wdata, l_rdata;

  kmt_ram #(.WIDTH(RWD), .DEPTH(PD)) u_killer_ram (
    .clk(clk), .we(k_we), .waddr(pply), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  kmt_ram #(.WIDTH($bits(move_t)), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  logic          acc;
  logic          ply_ok;
  logic [6:0]    ply_m1;
  logic [CW-1:0] cnt_base;
  logic          rd_hit;

  assign req_ready = (state == IDLE) && !rsp_valid;
  assign acc       = req_valid && req_ready;
  assign ply_ok    = (req.ply != 5'd0) && ({2'b00, req.ply} <= 7'(MAX_PLY));
  assign ply_m1    = {2'b00, req.ply} - 7'd1;
  assign cnt_base  = req.list_start ? '0 : count;
  assign rd_hit    = IW'(req.list_index) < IW'(count);

  // The killer row as stored, with a never-written row reading as all empty.
  slot_t [S-1:0] cur_row;
  assign cur_row = row_vld[pply] ? k_rdata : '0;

  // Update: first slot that is empty or scores at most the new move.
  logic          upd_found;
  slot_t [S-1:0] upd_row;
  always_comb begin
    int unsigned pos;
    upd_found = 1'b0;
    pos = 0;
    for (int u = 0; u < S; u++) begin
      if (!upd_found && (!cur_row[u].valid || (cur_row[u].mv.score <= pmv.score))) begin
        upd_found = 1'b1;
        pos = u;
      end
    end
    upd_row[0].valid = 1'b1;
    upd_row[0].mv    = pmv;
    for (int u = 1; u < S; u++) begin
      upd_row[u] = (u <= pos) ? cur_row[u-1] : cur_row[u];
    end
  end
  assign k_wdata = upd_row;

  // Scan: match the arriving list entry against the latched killer row.
  logic  sc_hit;
  move_t sc_mv;
  always_comb begin
    sc_hit = 1'b0;
    sc_mv  = '0;
    for (int u = 0; u < S; u++) begin
      if (!sc_hit && kr[u].valid &&
          (kr[u].mv.x == l_rdata.x) && (kr[u].mv.y == l_rdata.y)) begin
        sc_hit = 1'b1;
        sc_mv  = kr[u].mv;
      end
    end
  end

  logic [MW-1:0] m_next;
  logic [AW-1:0] last_next;
  logic          scan_done;
  assign m_next    = sc_hit ? m + MW'(1) : m;
  assign last_next = sc_hit ? scan_i : last;
  assign scan_done = (m_next == MW'(S)) || ((CW'(scan_i) + CW'(1)) == count);

  // Shift: an unmatched entry moves up by the matches found above it.
  logic          sh_match;
  logic [MW-1:0] sh_cnt;
  always_comb begin
    sh_match = 1'b0;
    sh_cnt   = '0;
    for (int u = 0; u < S; u++) begin
      if (MW'(u) < m) begin
        if (midx[u] == sh_j) sh_match = 1'b1;
        if (midx[u] > sh_j)  sh_cnt = sh_cnt + MW'(1);
      end
    end
  end

  move_t put_mv;
  always_comb begin
    put_mv = '0;
    for (int u = 0; u < S; u++) begin
      if (MW'(u) == k) put_mv = mmv[u];
    end
  end

  // RAM port steering.
  always_comb begin
    k_we    = (state == UPD) && upd_found;
    k_raddr = PW'(ply_m1);
    l_we    = 1'b0;
    l_waddr = AW'(cnt_base);
    l_wdata = '{x: req.move_x, y: req.move_y, score: req.move_score};
    l_raddr = AW'(req.list_index);
    case (state)
      IDLE: begin
        l_we = acc && (req.cmd == CMD_APPEND) && (cnt_base < CW'(LIST_DEPTH));
      end
      P_ROW: begin
        l_raddr = '0;
      end
      P_SCAN: begin
        l_raddr = scan_done ? last_next : scan_i + AW'(1);
      end
      P_SHIFT: begin
        l_we    = !sh_match;
        l_waddr = sh_j + AW'(sh_cnt);
        l_wdata = l_rdata;
        l_raddr = sh_j - AW'(1);
      end
      P_PUT: begin
        l_we    = 1'b1;
        l_waddr = AW'(k);
        l_wdata = put_mv;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      row_vld   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      case (state)
        IDLE: begin
          if (acc) begin
            pply <= PW'(ply_m1);
            pmv  <= '{x: req.move_x, y: req.move_y, score: req.move_score};
            case (req.cmd)
              CMD_UPDATE: begin
                if (ply_ok) state <= UPD;
              end
              CMD_APPEND: begin
                count <= (cnt_base < CW'(LIST_DEPTH)) ? cnt_base + CW'(1) : cnt_base;
              end
              CMD_PROMOTE: begin
                if (ply_ok && (count != '0)) state <= P_ROW;
              end
              CMD_READ: begin
                if (rd_hit) begin
                  state <= RD;
                end else begin
                  rsp       <= '0;
                  rsp_valid <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        UPD: begin
          if (upd_found) row_vld[pply] <= 1'b1;
          state <= IDLE;
        end
        RD: begin
          rsp       <= '{out_x: l_rdata.x, out_y: l_rdata.y,
                         out_score: l_rdata.score, out_valid: 1'b1};
          rsp_valid <= 1'b1;
          state     <= IDLE;
        end
        P_ROW: begin
          kr     <= cur_row;
          scan_i <= '0;
          m      <= '0;
          state  <= P_SCAN;
        end
        P_SCAN: begin
          if (sc_hit) begin
            for (int u = 0; u < S; u++) begin
              if (MW'(u) == m) begin
                midx[u] <= scan_i;
                mmv[u]  <= sc_mv;
              end
            end
          end
          m      <= m_next;
          last   <= last_next;
          scan_i <= scan_i + AW'(1);
          if (scan_done) begin
            sh_j  <= last_next;
            state <= (m_next == '0) ? IDLE : P_SHIFT;
          end
        end
        P_SHIFT: begin
          sh_j <= sh_j - AW'(1);
          if (sh_j == '0) begin
            k     <= '0;
            state <= P_PUT;
          end
        end
        P_PUT: begin
          k <= k + MW'(1);
          if ((k + MW'(1)) == m) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> tb/sv/killer_move_table_test.sv
// Testbench for killer_move_table: drives requests, predicts read responses
// with a behavioral copy of the killer slots and move list. Depends on kmt_pkg.
`default_nettype none
module killer_move_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kmt_pkg::*;

  localparam int MAX_PLY = 16;
  localparam int SLOTS = 2;
  localparam int DEPTH = 256;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  killer_move_table uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Behavioral copy of the block state.
  slot_t killers[MAX_PLY][SLOTS];
  move_t moves[DEPTH];
  int unsigned move_count;
  rsp_t pending_reads[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit recv_hold = 1'b0;
  int unsigned cycles = 0;
  int hold_cycles = 0;

  // Updates the ply's killer row the way the block does: first empty or
  // not-better slot wins, earlier slots shift down, new move goes in front.
  task automatic record_killer(input int p, input move_t m);
    int i;
    int j;
    for (i = 0; i < SLOTS; i++) begin
      if (!killers[p][i].valid || killers[p][i].mv.score <= m.score) begin
        for (j = i; j > 0; j--) killers[p][j] = killers[p][j-1];
        killers[p][0].valid = 1'b1;
        killers[p][0].mv = m;
        return;
      end
    end
  endtask

  // Moves list entries that match a killer to the front, in list order.
  task automatic promote_moves(input int p);
    int moved;
    int i;
    int j;
    int k;
    moved = 0;
    for (i = 0; i < move_count; i++) begin
      for (j = 0; j < SLOTS; j++)
        if (killers[p][j].valid && killers[p][j].mv.x == moves[i].x &&
            killers[p][j].mv.y == moves[i].y) break;
      if (j == SLOTS) continue;
      for (k = i; k > moved; k--) moves[k] = moves[k-1];
      moves[moved] = killers[p][j].mv;
      moved++;
      if (moved >= SLOTS) return;
    end
  endtask

  task automatic predict(input req_t r);
    rsp_t e;
    bit ply_ok;
    move_t m;
    ply_ok = r.ply >= 1 && r.ply <= MAX_PLY;
    m.x = r.move_x;
    m.y = r.move_y;
    m.score = r.move_score;
    case (r.cmd)
      CMD_UPDATE: begin
        if (ply_ok) record_killer(r.ply - 1, m);
      end
      CMD_APPEND: begin
        if (r.list_start) move_count = 0;
        if (move_count < DEPTH) begin
          moves[move_count] = m;
          move_count++;
        end
      end
      CMD_PROMOTE: begin
        if (ply_ok) promote_moves(r.ply - 1);
      end
      default: begin
        e = '0;
        if (r.list_index < move_count) begin
          e.out_x = moves[r.list_index].x;
          e.out_y = moves[r.list_index].y;
          e.out_score = moves[r.list_index].score;
          e.out_valid = 1'b1;
        end
        pending_reads.push_back(e);
      end
    endcase
  endtask

  // Sends one request, idling beforehand according to the current rate.
  // Valid stays high after acceptance until the next request or an idle cycle.
  task automatic send(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    predict(r);
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Random request; reads may index past the written entries, which count
  // gating answers with an empty response.
  function automatic req_t rand_req(input int wa, input int wu, input int wp);
    req_t r;
    int pick;
    r.cmd = CMD_READ;
    r.ply = 5'($urandom_range(1, 4));
    if ($urandom_range(19) == 0) r.ply = 5'($urandom_range(31));
    r.move_x = 5'($urandom_range(3));
    r.move_y = 5'($urandom_range(3));
    if ($urandom_range(9) == 0) begin
      r.move_x = 5'($urandom);
      r.move_y = 5'($urandom);
    end
    r.move_score = $urandom_range(40) - 20;
    if ($urandom_range(9) == 0) r.move_score = $urandom;
    r.list_index = 8'($urandom_range(move_count + 3));
    if ($urandom_range(19) == 0) r.list_index = 8'($urandom);
    r.list_start = $urandom_range(24) == 0;
    pick = $urandom_range(99);
    if (pick < wa) r.cmd = CMD_APPEND;
    else if (pick < wa + wu) r.cmd = CMD_UPDATE;
    else if (pick < wa + wu + wp) r.cmd = CMD_PROMOTE;
    return r;
  endfunction

  function automatic req_t mk(input logic [1:0] c, input int p, input int x,
                              input int y, input int s, input int idx,
                              input bit st);
    req_t r;
    r.cmd = c; r.ply = 5'(p); r.move_x = 5'(x); r.move_y = 5'(y);
    r.move_score = s; r.list_index = 8'(idx); r.list_start = st;
    return r;
  endfunction

  task automatic drain();
    req_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Directed: field extremes, all commands, out-of-range plies, ties,
  // drops, duplicate killers, promote limit, read past count.
  task automatic test_directed();
    send(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_APPEND, 0, 31, 31, 32'h7fffffff, 0, 1));
    send(mk(CMD_APPEND, 0, 0, 0, 32'h80000000, 255, 0));
    send(mk(CMD_APPEND, 0, 5, 6, 7, 0, 0));
    send(mk(CMD_APPEND, 0, 31, 31, 1, 0, 0));
    send(mk(CMD_UPDATE, 0, 0, 0, 9, 0, 0));
    send(mk(CMD_UPDATE, 17, 0, 0, 9, 0, 0));
    send(mk(CMD_UPDATE, 31, 0, 0, 9, 0, 0));
    send(mk(CMD_UPDATE, 16, 31, 31, 32'h80000000, 0, 0));
    send(mk(CMD_UPDATE, 16, 31, 31, 32'h80000000, 0, 0));
    send(mk(CMD_UPDATE, 16, 5, 6, 32'h7fffffff, 0, 0));
    send(mk(CMD_UPDATE, 1, 9, 9, 3, 0, 0));
    send(mk(CMD_UPDATE, 1, 8, 8, 3, 0, 0));
    send(mk(CMD_UPDATE, 1, 7, 7, 2, 0, 0));
    send(mk(CMD_PROMOTE, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_PROMOTE, 17, 0, 0, 0, 0, 0));
    send(mk(CMD_PROMOTE, 16, 0, 0, 0, 0, 0));
    send(mk(CMD_PROMOTE, 1, 0, 0, 0, 0, 0));
    for (int i = 0; i < 5; i++) send(mk(CMD_READ, 0, 0, 0, 0, i, 0));
    send(mk(CMD_READ, 31, 31, 31, -1, 255, 1));
    drain();
  endtask

  // Fills the list past its depth so the count saturates, then reads the top.
  task automatic test_full_list();
    send(mk(CMD_APPEND, 0, 1, 1, 0, 0, 1));
    for (int i = 1; i < DEPTH + 3; i++)
      send(mk(CMD_APPEND, 0, $urandom, $urandom, $urandom, 0, 0));
    send(mk(CMD_UPDATE, 2, 1, 1, 4, 0, 0));
    send(mk(CMD_PROMOTE, 2, 0, 0, 0, 0, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 255, 0));
    send(mk(CMD_READ, 0, 0, 0, 0, 0, 0));
    drain();
  endtask

  // Well-formed search rounds with random content: build a short list, record
  // a few killers, promote, read everything back. Some noise mixed in.
  task automatic test_random(input int rounds);
    int n;
    for (int k = 0; k < rounds; k++) begin
      n = $urandom_range(2, 8);
      send(mk(CMD_APPEND, 0, $urandom_range(3), $urandom_range(3),
              $urandom_range(20), 0, 1));
      for (int i = 1; i < n; i++) send(rand_req(100, 0, 0));
      repeat ($urandom_range(1, 3)) send(rand_req(0, 100, 0));
      send(rand_req(0, 0, 100));
      for (int i = 0; i < n; i++) send(mk(CMD_READ, 0, 0, 0, 0, i, 0));
      if ($urandom_range(3) == 0) send(rand_req(25, 25, 25));
    end
  endtask

  // Receiver holds off while requests keep coming, so the block backs up.
  task automatic test_backpressure();
    recv_hold = 1'b1;
    for (int i = 0; i < 12; i++) send(mk(CMD_READ, 0, 0, 0, 0, i % 4, 0));
    recv_hold = 1'b0;
    drain();
  endtask

  // Length of the current hold-off window, in cycles.
  always @(posedge clk) begin
    if (recv_hold) hold_cycles <= hold_cycles + 1;
    else hold_cycles <= 0;
  end

  // Response side: random stall, hold-off window, in-order comparison.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    rsp_ready <= !(recv_hold && hold_cycles < 200) &&
                 ($urandom_range(99) >= recv_stall_pct);
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_reads.size() == 0) begin
        $error("response with no read outstanding");
        errors = errors + 1;
      end else begin
        rsp_t e;
        e = pending_reads.pop_front();
        if (rsp.out_x !== e.out_x) begin
          $error("out_x: expected %0d, got %0d", e.out_x, rsp.out_x);
          errors = errors + 1;
        end
        if (rsp.out_y !== e.out_y) begin
          $error("out_y: expected %0d, got %0d", e.out_y, rsp.out_y);
          errors = errors + 1;
        end
        if (rsp.out_score !== e.out_score) begin
          $error("out_score: expected %0d, got %0d", e.out_score, rsp.out_score);
          errors = errors + 1;
        end
        if (rsp.out_valid !== e.out_valid) begin
          $error("out_valid: expected %0d, got %0d", e.out_valid, rsp.out_valid);
          errors = errors + 1;
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("** killer_move_table: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < MAX_PLY; p++)
      for (int s = 0; s < SLOTS; s++) killers[p][s] = '0;
    for (int i = 0; i < DEPTH; i++) moves[i] = '0;
    move_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_list();
    test_backpressure();
    test_random(6);
    send_idle_pct = 71;
    test_random(6);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 71;
    test_random(6);
    send_idle_pct = 19;
    recv_stall_pct = 19;
    test_random(6);
    drain();
    if (errors == 0 && pending_reads.size() == 0) begin
      $display("** killer_move_table: PASSED **");
    end else begin
      $display("** killer_move_table: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
